// ===== design/tmcw_pkg.sv =====
package tmcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLUMNS * ROWS;

  localparam int ACT_W = 3;
  localparam int CHAR_W = 8;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int RAM_AW = $clog2(CELLS);

  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 40;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTRIBUTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURSOR_ENABLE = 1'd1;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;
  localparam int RESET_LINE = 10;
  localparam int RESET_ROW = (RESET_LINE < ROWS) ? RESET_LINE : ROWS - 1;

  localparam logic [CHAR_W-1:0] CH_BS = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
  localparam int TAB_STEP = 8;

  typedef enum logic [ACT_W-1:0] {
    ACT_TTY   = 3'd0,
    ACT_GLYPH = 3'd1,
    ACT_CLEAR = 3'd2,
    ACT_PLACE = 3'd3,
    ACT_READ  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_SCROLL,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [ADDR_W-1:0] cursor_address;
    logic              cursor_update;
  } cursor_t;

  typedef struct packed {
    op_e                op;
    logic               wr_en;
    logic [RAM_AW-1:0]  addr;
    logic [CELL_W-1:0]  wr_data;
    logic [ATTR_W-1:0]  attr;
    cursor_t            cursor;
  } cmd_t;

  typedef struct packed {
    cursor_t           cursor;
    logic [CELL_W-1:0] cell_value;
  } res_t;

endpackage

// ===== design/tmcw_ram.sv =====
module tmcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== design/tmcw_front.sv =====
module tmcw_front import tmcw_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ATTR_W-1:0]    cfg_wdata_i,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  logic [ACT_W-1:0]     action_i,
  input  logic [CHAR_W-1:0]    character_i,
  input  logic [COL_W-1:0]     column_i,
  input  logic [ROW_W-1:0]     row_i,
  output logic                 push_o,
  output cmd_t                 cmd_o,
  input  logic                 full_i
);

  logic [ATTR_W-1:0] attr_q;
  logic              cur_en_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W:0]    col_n;
  logic [ROW_W:0]    row_n;
  logic [COL_W-1:0]  col_clamp;
  logic [ROW_W-1:0]  row_clamp;
  logic              do_write;
  logic              do_wrap;
  logic              accept;

  assign req_ready_o = !full_i;
  assign accept = req_valid_i && !full_i;
  assign push_o = accept;

  assign col_clamp = (column_i >= COL_W'(COLUMNS)) ? COL_W'(COLUMNS - 1) : column_i;
  assign row_clamp = (row_i >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : row_i;

  always_comb begin
    col_n = {1'b0, col_q};
    row_n = {1'b0, row_q};
    do_write = 1'b0;
    do_wrap = 1'b0;
    cmd_o = '0;
    cmd_o.op = OP_NONE;
    cmd_o.attr = attr_q;
    case (action_i)
      ACT_TTY: begin
        do_wrap = 1'b1;
        if (character_i == CH_BS) begin
          if (col_q != '0) begin
            col_n = col_n - (COL_W + 1)'(1);
          end
        end else if (character_i == CH_TAB) begin
          col_n = (col_n + (COL_W + 1)'(TAB_STEP)) & ~(COL_W + 1)'(TAB_STEP - 1);
        end else if (character_i == CH_CR) begin
          col_n = '0;
        end else if (character_i == CH_LF) begin
          col_n = '0;
          row_n = row_n + (ROW_W + 1)'(1);
        end else if (character_i >= CH_BLANK) begin
          do_write = 1'b1;
          col_n = col_n + (COL_W + 1)'(1);
        end
      end
      ACT_GLYPH: begin
        do_wrap = 1'b1;
        do_write = 1'b1;
        col_n = col_n + (COL_W + 1)'(1);
      end
      ACT_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        col_n = '0;
        row_n = '0;
      end
      ACT_PLACE: begin
        col_n = {1'b0, col_clamp};
        row_n = {1'b0, row_clamp};
      end
      ACT_READ: begin
        cmd_o.op = OP_READ;
        cmd_o.addr = RAM_AW'(row_clamp) * RAM_AW'(COLUMNS) + RAM_AW'(col_clamp);
      end
      default: begin
      end
    endcase
    if (do_wrap) begin
      if (col_n >= (COL_W + 1)'(COLUMNS)) begin
        col_n = '0;
        row_n = row_n + (ROW_W + 1)'(1);
      end
      if (row_n >= (ROW_W + 1)'(ROWS)) begin
        cmd_o.op = OP_SCROLL;
        row_n = (ROW_W + 1)'(ROWS - 1);
      end
    end
    if (do_write) begin
      cmd_o.wr_en = 1'b1;
      cmd_o.addr = RAM_AW'(row_q) * RAM_AW'(COLUMNS) + RAM_AW'(col_q);
      cmd_o.wr_data = {attr_q, character_i};
    end
    col_d = col_n[COL_W-1:0];
    row_d = row_n[ROW_W-1:0];
    cmd_o.cursor.cursor_column = col_d;
    cmd_o.cursor.cursor_row = row_d;
    cmd_o.cursor.cursor_address = ADDR_W'(row_d) * ADDR_W'(COLUMNS) + ADDR_W'(col_d);
    cmd_o.cursor.cursor_update = cur_en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      cur_en_q <= 1'b1;
      col_q <= '0;
      row_q <= ROW_W'(RESET_ROW);
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ATTRIBUTE: attr_q <= cfg_wdata_i;
          CFG_CURSOR_ENABLE: cur_en_q <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

// ===== design/tmcw_queue.sv =====
module tmcw_queue import tmcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic valid_o
);

  cmd_t              buf_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o = (count_q == (QPTR_W + 1)'(QDEPTH));
  assign valid_o = (count_q != '0);
  assign head_o = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (QPTR_W + 1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== design/tmcw_back.sv =====
module tmcw_back import tmcw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  input  cmd_t q_head_i,
  output logic pop_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  output res_t res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

  state_e             state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q;
  res_t               out_q;
  logic               free;
  logic               load;
  res_t               load_res;
  logic               ram_we;
  logic [RAM_AW-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata;
  logic               ram_re;
  logic [RAM_AW-1:0]  ram_raddr;
  logic [CELL_W-1:0]  ram_rdata;

  assign free = !out_valid_q || res_ready_i;
  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

  tmcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q;
    cnt_d = cnt_q;
    pop_o = 1'b0;
    load = 1'b0;
    load_res = '0;
    ram_we = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re = 1'b0;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_head_i.op == OP_NONE) begin
            if (free) begin
              pop_o = 1'b1;
              ram_we = q_head_i.wr_en;
              ram_waddr = q_head_i.addr;
              ram_wdata = q_head_i.wr_data;
              load = 1'b1;
              load_res.cursor = q_head_i.cursor;
            end
          end else begin
            pop_o = 1'b1;
            cmd_d = q_head_i;
            cnt_d = '0;
            ram_we = q_head_i.wr_en;
            ram_waddr = q_head_i.addr;
            ram_wdata = q_head_i.wr_data;
            case (q_head_i.op)
              OP_READ: begin
                ram_re = 1'b1;
                ram_raddr = q_head_i.addr;
                state_d = ST_DONE;
              end
              OP_SCROLL: state_d = ST_SCROLL;
              OP_CLEAR: state_d = ST_BLANK;
              default: state_d = ST_DONE;
            endcase
          end
        end
      end
      ST_SCROLL: begin
        // row copy: read one row down, write the previous address from the registered read data
        if (cnt_q != CNT_W'(CELLS - COLUMNS)) begin
          ram_re = 1'b1;
          ram_raddr = RAM_AW'(cnt_q + CNT_W'(COLUMNS));
          cnt_d = cnt_q + CNT_W'(1);
        end else begin
          state_d = ST_BLANK;
        end
        if (cnt_q != '0) begin
          ram_we = 1'b1;
          ram_waddr = RAM_AW'(cnt_q - CNT_W'(1));
          ram_wdata = ram_rdata;
        end
      end
      ST_BLANK: begin
        ram_we = 1'b1;
        ram_waddr = RAM_AW'(cnt_q);
        ram_wdata = {cmd_q.attr, CH_BLANK};
        if (cnt_q == CNT_W'(CELLS - 1)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (free) begin
          load = 1'b1;
          load_res.cursor = cmd_q.cursor;
          load_res.cell_value = (cmd_q.op == OP_READ) ? ram_rdata : '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (load) begin
      out_q <= load_res;
    end
  end

endmodule

// ===== design/text_mode_console_writer.sv =====
// Teletype engine for an 80x25 text screen of 16-bit cells (attribute high byte,
// character low byte) held in one single-port-write screen RAM. A front stage
// takes one request per cycle while the queue is not full, moves the cursor and
// queues the screen operation (queue of 4); a back stage carries it out on the RAM
// and returns one result per request. A scroll or a clear holds the back stage
// while it rewrites the screen, one cell per cycle through the RAM write port;
// later requests queue behind them. Results come in request order.
module text_mode_console_writer import tmcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ATTR_W-1:0]     cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // action[2:0], character[10:3], column[17:11], row[22:18], zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // cursor_column[6:0], cursor_row[11:7], cursor_address[22:12],
  // cursor_update[23], cell_value[39:24]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t q_head;
  logic q_valid;
  res_t res;

  tmcw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_valid_i(s_axis_tvalid),
    .req_ready_o(s_axis_tready),
    .action_i   (s_axis_tdata[2:0]),
    .character_i(s_axis_tdata[10:3]),
    .column_i   (s_axis_tdata[17:11]),
    .row_i      (s_axis_tdata[22:18]),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .full_i     (q_full)
  );

  tmcw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .head_o     (q_head),
    .valid_o    (q_valid)
  );

  tmcw_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_head_i   (q_head),
    .pop_o      (pop),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {res.cell_value, res.cursor.cursor_update,
                         res.cursor.cursor_address, res.cursor.cursor_row,
                         res.cursor.cursor_column};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.cursor.cursor_column < COL_W'(COLUMNS)) &&
                      (res.cursor.cursor_row < ROW_W'(ROWS)))
    else $error("result cursor off screen");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.cursor.cursor_address ==
      ADDR_W'(res.cursor.cursor_row) * ADDR_W'(COLUMNS) + ADDR_W'(res.cursor.cursor_column))
    else $error("cursor address does not match row and column");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

// ===== test/tmcw_result_checker.sv =====
module tmcw_result_checker import tmcw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ATTR_W-1:0]     cfg_wdata_i,
  input  logic                  req_valid_i,
  input  logic                  req_ready_i,
  // action[2:0], character[10:3], column[17:11], row[22:18], zero pad
  input  logic [IN_DATA_W-1:0]  req_data_i,
  input  logic                  rsp_valid_i,
  input  logic                  rsp_ready_i,
  // cursor_column[6:0], cursor_row[11:7], cursor_address[22:12],
  // cursor_update[23], cell_value[39:24]
  input  logic [OUT_DATA_W-1:0] rsp_data_i,
  output int                    errors_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  logic [CELL_W-1:0] screen [CELLS];
  int                cur_col;
  int                cur_line;
  logic [ATTR_W-1:0] attr;
  logic              cur_en;
  res_t              due_reports [$];
  int                errors = 0;
  int                pending = 0;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic logic [CELL_W-1:0] blank_cell();
    return {attr, CH_BLANK};
  endfunction

  function automatic int clamp(int v, int lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  function automatic void put_char(logic [CHAR_W-1:0] ch);
    screen[cur_line * COLUMNS + cur_col] = {attr, ch};
  endfunction

  // wrap at end of line, scroll up one row past the bottom
  function automatic void wrap_cursor();
    if (cur_col >= COLUMNS) begin
      cur_col = 0;
      cur_line++;
    end
    if (cur_line >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = CELLS - COLUMNS; i < CELLS; i++) screen[i] = blank_cell();
      cur_line = ROWS - 1;
    end
  endfunction

  function automatic res_t apply_action(logic [IN_DATA_W-1:0] req);
    logic [ACT_W-1:0]  act;
    logic [CHAR_W-1:0] ch;
    int                col;
    int                row;
    res_t              r;
    act = req[2:0];
    ch  = req[10:3];
    col = clamp(int'(req[17:11]), COLUMNS);
    row = clamp(int'(req[22:18]), ROWS);
    r   = '0;
    case (act)
      ACT_TTY: begin
        if (ch == CH_BS) begin
          if (cur_col != 0) cur_col--;
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_LF) begin
          cur_col = 0;
          cur_line++;
        end else if (ch >= CH_BLANK) begin
          put_char(ch);
          cur_col++;
        end
        wrap_cursor();
      end
      ACT_GLYPH: begin
        put_char(ch);
        cur_col++;
        wrap_cursor();
      end
      ACT_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = blank_cell();
        cur_col  = 0;
        cur_line = 0;
      end
      ACT_PLACE: begin
        cur_col  = col;
        cur_line = row;
      end
      ACT_READ: begin
        r.cell_value = screen[row * COLUMNS + col];
      end
      default: begin
      end
    endcase
    r.cursor.cursor_column  = COL_W'(cur_col);
    r.cursor.cursor_row     = ROW_W'(cur_line);
    r.cursor.cursor_address = ADDR_W'(cur_line * COLUMNS + cur_col);
    r.cursor.cursor_update  = cur_en;
    return r;
  endfunction

  function automatic void flag(string msg);
    if (errors < MAX_REPORTS) $display("mismatch: %s", msg);
    errors++;
  endfunction

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      cur_col  = 0;
      cur_line = RESET_ROW;
      attr     = ATTR_RESET;
      cur_en   = 1'b1;
      due_reports.delete();
      pending  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_ATTRIBUTE) attr = cfg_wdata_i;
        else if (cfg_index_i == CFG_CURSOR_ENABLE) cur_en = cfg_wdata_i[0];
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got.cursor.cursor_column  = rsp_data_i[6:0];
        got.cursor.cursor_row     = rsp_data_i[11:7];
        got.cursor.cursor_address = rsp_data_i[22:12];
        got.cursor.cursor_update  = rsp_data_i[23];
        got.cell_value            = rsp_data_i[39:24];
        if (due_reports.size() == 0) begin
          flag($sformatf("result %h with no request outstanding", rsp_data_i));
        end else begin
          want = due_reports.pop_front();
          pending--;
          if (got != want)
            flag($sformatf({"expected col %0d row %0d addr %0d upd %0b cell %h, ",
                            "got col %0d row %0d addr %0d upd %0b cell %h"},
                           want.cursor.cursor_column, want.cursor.cursor_row,
                           want.cursor.cursor_address, want.cursor.cursor_update,
                           want.cell_value,
                           got.cursor.cursor_column, got.cursor.cursor_row,
                           got.cursor.cursor_address, got.cursor.cursor_update,
                           got.cell_value));
        end
      end
      if (req_valid_i && req_ready_i) begin
        due_reports.push_back(apply_action(req_data_i));
        pending++;
      end
    end
  end

endmodule

// ===== test/tb_text_mode_console_writer.sv =====
module tb_text_mode_console_writer import tmcw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [ACT_W-1:0] ACT_FIRST_SPARE = 3'd5;
  localparam logic [ACT_W-1:0] ACT_LAST_SPARE  = 3'd7;

  typedef enum int {
    FLOW_FREE,
    FLOW_SRC_IDLE,
    FLOW_SINK_STALL,
    FLOW_BOTH
  } flow_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [ATTR_W-1:0]     cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  // action[2:0], character[10:3], column[17:11], row[22:18], zero pad
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  // cursor_column[6:0], cursor_row[11:7], cursor_address[22:12],
  // cursor_update[23], cell_value[39:24]
  logic [OUT_DATA_W-1:0] m_tdata;
  int                    errors;
  int                    pending;
  int                    sent = 0;
  int                    hold_req = 0;
  int                    cycles = 0;
  flow_e                 flow = FLOW_FREE;

  text_mode_console_writer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  tmcw_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .req_valid_i (s_tvalid),
    .req_ready_i (s_tready),
    .req_data_i  (s_tdata),
    .rsp_valid_i (m_tvalid),
    .rsp_ready_i (m_tready),
    .rsp_data_i  (m_tdata),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int src_idle_pct();
    case (flow)
      FLOW_SRC_IDLE: return 52;
      FLOW_BOTH:     return 8;
      default:       return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct();
    case (flow)
      FLOW_SINK_STALL: return 52;
      FLOW_BOTH:       return 8;
      default:         return 0;
    endcase
  endfunction

  function automatic logic [COL_W-1:0] rand_col();
    if ($urandom_range(0, 3) == 0) return COL_W'($urandom);
    return COL_W'($urandom_range(0, COLUMNS - 1));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    return ROW_W'($urandom);
  endfunction

  // result sink, with a long hold-off whenever one is requested
  initial begin
    int holds_done;
    int hold_left;
    m_tready   = 1'b0;
    holds_done = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && holds_done != hold_req) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct());
      end
    end
  end

  task automatic send_req(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct()) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, row, col, ch, act};
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ATTR_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_burst();
    int                pick;
    int                len;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      // a line of text, often ended by carriage return and line feed
      len = $urandom_range(1, 24);
      repeat (len)
        send_req(ACT_TTY, CHAR_W'($urandom_range(CH_BLANK, 8'hFF)), rand_col(), rand_row());
      if ($urandom_range(0, 2) == 0) begin
        send_req(ACT_TTY, CH_CR, rand_col(), rand_row());
        send_req(ACT_TTY, CH_LF, rand_col(), rand_row());
      end
    end else if (pick < 45) begin
      send_req(ACT_PLACE, CHAR_W'($urandom), rand_col(), rand_row());
    end else if (pick < 62) begin
      send_req(ACT_READ, CHAR_W'($urandom), rand_col(), rand_row());
    end else if (pick < 72) begin
      send_req(ACT_GLYPH, CHAR_W'($urandom), rand_col(), rand_row());
    end else if (pick < 88) begin
      case ($urandom_range(0, 4))
        0:       ch = CH_BS;
        1:       ch = CH_TAB;
        2:       ch = CH_CR;
        3:       ch = CH_LF;
        default: ch = CHAR_W'($urandom_range(0, CH_BLANK - 1));
      endcase
      send_req(ACT_TTY, ch, rand_col(), rand_row());
    end else if (pick < 89) begin
      send_req(ACT_CLEAR, CHAR_W'($urandom), rand_col(), rand_row());
    end else if (pick < 91) begin
      send_req(ACT_W'($urandom_range(ACT_FIRST_SPARE, ACT_LAST_SPARE)), CHAR_W'($urandom),
               rand_col(), rand_row());
    end else begin
      send_req(ACT_W'($urandom_range(0, ACT_LAST_SPARE)), CHAR_W'($urandom),
               rand_col(), rand_row());
    end
  endtask

  task automatic run_phase(input logic [ATTR_W-1:0] attr_val, input logic en,
                           input flow_e mode, input int items, input logic hold);
    int target;
    wait_idle();
    write_reg(CFG_ATTRIBUTE, attr_val);
    write_reg(CFG_CURSOR_ENABLE, {(ATTR_W - 1)'($urandom), en});
    flow = mode;
    if (hold) hold_req++;
    target = sent + items;
    while (sent < target) random_burst();
    stop_sending();
  endtask

  initial begin
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = CFG_ATTRIBUTE;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // from the reset cursor, no reads until the screen is cleared
    send_req(ACT_TTY, 8'h41, '0, '0);
    send_req(ACT_TTY, CH_BS, '0, '0);
    send_req(ACT_TTY, CH_BS, '0, '0);
    send_req(ACT_TTY, CH_TAB, '0, '0);
    send_req(ACT_TTY, CH_CR, '0, '0);
    send_req(ACT_TTY, CH_LF, '0, '0);
    send_req(ACT_TTY, 8'h01, '0, '0);
    send_req(ACT_GLYPH, 8'h00, '0, '0);
    send_req(ACT_CLEAR, 8'hFF, '1, '1);
    send_req(ACT_READ, '0, '0, '0);
    // placement past the edges, then wrap and scroll from the last cell
    send_req(ACT_PLACE, '0, '1, '1);
    send_req(ACT_TTY, 8'h5A, '0, '0);
    send_req(ACT_READ, '0, 7'd79, 5'd23);
    send_req(ACT_READ, '0, '1, '1);
    // tab from the last columns wraps
    send_req(ACT_PLACE, '0, 7'd79, 5'd0);
    send_req(ACT_TTY, CH_TAB, '0, '0);
    send_req(ACT_PLACE, '0, 7'd72, 5'd5);
    send_req(ACT_TTY, CH_TAB, '0, '0);
    send_req(ACT_TTY, 8'hFF, '0, '0);
    send_req(ACT_TTY, 8'h7F, '0, '0);
    send_req(ACT_TTY, 8'h80, '0, '0);
    send_req(ACT_TTY, CH_BLANK, '0, '0);
    send_req(ACT_GLYPH, CH_LF, '0, '0);
    // line feed on the bottom row scrolls
    send_req(ACT_PLACE, '0, 7'd0, 5'd24);
    send_req(ACT_TTY, CH_LF, '0, '0);
    send_req(ACT_FIRST_SPARE, 8'h41, '1, '1);
    send_req(ACT_LAST_SPARE, 8'h42, '0, '0);
    send_req(ACT_READ, '0, 7'd5, 5'd6);
    stop_sending();

    run_phase(8'h00, 1'b0, FLOW_FREE, 250, 1'b1);
    run_phase(8'hFF, 1'b1, FLOW_SRC_IDLE, 300, 1'b0);
    run_phase(ATTR_W'($urandom), 1'b1, FLOW_SINK_STALL, 300, 1'b0);
    run_phase(ATTR_W'($urandom), 1'b0, FLOW_BOTH, 300, 1'b0);
    run_phase(ATTR_W'($urandom), 1'b1, FLOW_FREE, 300, 1'b1);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
